### sv/zipc_pkg.sv
// Shared constants, types and key-schedule functions for the ZipCrypto stream cipher.
package zipc_pkg;

  localparam logic [31:0] KEY0_INIT = 32'h12345678;
  localparam logic [31:0] KEY1_INIT = 32'h23456789;
  localparam logic [31:0] KEY2_INIT = 32'h34567890;
  localparam logic [31:0] LCG_MULT  = 32'h08088405;
  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;

  typedef enum logic [1:0] {
    OP_RESTART = 2'd0,
    OP_ABSORB  = 2'd1,
    OP_DATA    = 2'd2
  } opcode_t;

  // Command from the handshake logic to the key registers
  typedef struct packed {
    logic       load;
    logic       absorb;
    logic [7:0] plain;
  } key_cmd_t;

  // One entry of the reflected CRC-32 table
  function automatic logic [31:0] crc_entry(input logic [7:0] idx);
    logic [31:0] c;
    c = {24'd0, idx};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
    return crc_entry(crc[7:0] ^ b) ^ {8'd0, crc[31:8]};
  endfunction

  function automatic logic [7:0] stream_byte(input logic [31:0] k2);
    logic [15:0] t;
    logic [15:0] prod;
    t    = k2[15:0] | 16'h0002;
    prod = t * (t ^ 16'h0001);
    return prod[15:8];
  endfunction

endpackage

### sv/zipc_ifs.sv
// Channel interfaces: input items, result items and the mode write channel.
interface zipc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] byte_value;
  logic       last_in;
  modport source (output valid, opcode, byte_value, last_in, input ready);
  modport sink (input valid, opcode, byte_value, last_in, output ready);
endinterface

interface zipc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_out;
  modport source (output valid, out_byte, last_out, input ready);
  modport sink (input valid, out_byte, last_out, output ready);
endinterface

interface zipc_cfg_if;
  logic valid;
  logic ready;
  logic encrypt_mode;
  modport source (output valid, encrypt_mode, input ready);
  modport sink (input valid, encrypt_mode, output ready);
endinterface

### sv/zipc_keys.sv
// Key registers with the CRC-32 / LCG update and the keystream byte.
module zipc_keys (
  input  logic              clk,
  input  logic              rst,
  input  zipc_pkg::key_cmd_t cmd,
  output logic [7:0]        ks
);
  import zipc_pkg::*;

  logic [31:0] key_zero, key_one, key_two;
  logic [31:0] key_zero_next, key_one_next, key_two_next;

  always_comb begin
    key_zero_next = crc_step(key_zero, cmd.plain);
    // constant multiplier: a handful of shifted adds
    key_one_next  = (key_one + {24'd0, key_zero_next[7:0]}) * LCG_MULT + 32'd1;
    key_two_next  = crc_step(key_two, key_one_next[31:24]);
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      key_zero <= KEY0_INIT;
      key_one  <= KEY1_INIT;
      key_two  <= KEY2_INIT;
    end else if (cmd.absorb) begin
      key_zero <= key_zero_next;
      key_one  <= key_one_next;
      key_two  <= key_two_next;
    end
  end

  assign ks = stream_byte(key_two);

endmodule

### sv/zip_traditional_stream_cipher.sv
// Top level of the ZipCrypto byte stream cipher.
//   channel | dir | handshake     | payload
//   din     | in  | valid/ready   | opcode, byte_value, last_in
//   dout    | out | valid/ready   | out_byte, last_out
//   cfg     | in  | valid/ready   | encrypt_mode (ready always high)
// One item per cycle sustained while results are taken; an item is held in the input register,
// and a data byte's result is loaded into the result register as the item leaves it.
// The key feedback (keystream multiply, CRC step, LCG step, CRC step) is combinational
// from the key registers back to them. Reset loads the key constants and clears both stages and the mode.
// A stalled result holds only data items back; restart and password items pass.
module zip_traditional_stream_cipher (
  input logic     clk,
  input logic     rst,
  zipc_in_if.sink  din,
  zipc_out_if.source dout,
  zipc_cfg_if.sink cfg
);
  import zipc_pkg::*;

  logic       encrypt_mode;
  logic       s1_valid;
  opcode_t    s1_op;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       res_valid;
  logic [7:0] res_byte;
  logic       res_last;

  logic       s1_adv;
  logic       s1_is_data;
  logic [7:0] ks;
  logic [7:0] r;
  key_cmd_t   cmd;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      encrypt_mode <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      encrypt_mode <= cfg.encrypt_mode;
    end
  end

  assign s1_is_data = (s1_op == OP_DATA);
  assign s1_adv     = s1_valid && (!s1_is_data || !res_valid || dout.ready);
  assign din.ready  = !s1_valid || s1_adv;
  assign r          = s1_byte ^ ks;

  always_comb begin
    cmd.load   = 1'b0;
    cmd.absorb = 1'b0;
    cmd.plain  = s1_byte;
    unique case (s1_op)
      OP_RESTART: cmd.load = s1_adv;
      OP_ABSORB:  cmd.absorb = s1_adv;
      OP_DATA: begin
        cmd.absorb = s1_adv;
        cmd.plain  = encrypt_mode ? s1_byte : r;
      end
      default: ;
    endcase
  end

  zipc_keys u_keys (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .ks  (ks)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (din.valid && din.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (din.valid && din.ready) begin
      s1_op   <= opcode_t'(din.opcode);
      s1_byte <= din.byte_value;
      s1_last <= din.last_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv && s1_is_data) begin
      res_valid <= 1'b1;
    end else if (dout.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_is_data) begin
      res_byte <= r;
      res_last <= s1_last;
    end
  end

  assign dout.valid    = res_valid;
  assign dout.out_byte = res_byte;
  assign dout.last_out = res_last;

`ifndef SYNTH
  a_reset_empty: assert property (@(posedge clk) rst |=> (!s1_valid && !res_valid))
    else $error("pipeline not empty after reset");

  a_rise_from_data: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(s1_valid && s1_op == OP_DATA))
    else $error("result appeared without a data item");

  a_data_held: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_is_data && res_valid && !dout.ready) |=> (s1_valid && $stable(s1_byte)))
    else $error("data item lost while result stalled");
`endif

endmodule

### verif/zip_traditional_stream_cipher_tb.sv
// Self-checking testbench for the ZipCrypto stream cipher: directed, random and stall tests.
module zip_traditional_stream_cipher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import zipc_pkg::*;

  localparam logic [31:0] K0_SEED       = 32'h12345678;
  localparam logic [31:0] K1_SEED       = 32'h23456789;
  localparam logic [31:0] K2_SEED       = 32'h34567890;
  localparam logic [31:0] LCG_FACTOR    = 32'h08088405;
  localparam logic [31:0] CRC_REFLECTED = 32'hEDB88320;
  localparam logic [1:0]  OP_UNUSED     = 2'd3;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 80;
  localparam int STALL_LIMIT   = 400;
  localparam int RANDOM_ITEMS  = 550;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } cipher_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  zipc_in_if  din_if ();
  zipc_out_if dout_if ();
  zipc_cfg_if cfg_if ();

  zip_traditional_stream_cipher dut (
    .clk (clk),
    .rst (rst),
    .din (din_if),
    .dout(dout_if),
    .cfg (cfg_if)
  );

  always #5 clk = ~clk;

  // Key state and mode as the block should hold them
  logic [31:0] key0_model = K0_SEED;
  logic [31:0] key1_model = K1_SEED;
  logic [31:0] key2_model = K2_SEED;
  logic        mode_model = 1'b0;

  cipher_result_t pending_results[$];
  int  mismatches   = 0;
  int  items_sent   = 0;
  int  stuck_cycles = 0;
  bit  calm         = 1'b0;
  bit  hold_results = 1'b0;

  function automatic logic [31:0] crc_advance(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    int i;
    c = crc ^ {24'd0, b};
    for (i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_REFLECTED) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] keystream_byte(input logic [31:0] k2);
    logic [31:0] t;
    logic [31:0] p;
    t = {16'd0, k2[15:0]} | 32'd2;
    p = t * (t ^ 32'd1);
    return p[15:8];
  endfunction

  function automatic void cipher_absorb(input logic [7:0] plain);
    key0_model = crc_advance(key0_model, plain);
    key1_model = (key1_model + {24'd0, key0_model[7:0]}) * LCG_FACTOR + 32'd1;
    key2_model = crc_advance(key2_model, key1_model[31:24]);
  endfunction

  // Result check first, then prediction: a result never belongs to an item of the same edge
  always @(posedge clk) begin : cipher_check
    cipher_result_t want;
    logic [7:0] coded;
    if (!rst) begin
      if (dout_if.valid && dout_if.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual out_byte=%02h last_out=%0b",
                   $time, dout_if.out_byte, dout_if.last_out);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (dout_if.out_byte !== want.data) begin
            $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                     $time, want.data, dout_if.out_byte);
            mismatches++;
          end
          if (dout_if.last_out !== want.last) begin
            $display("%0t: last_out mismatch: expected %0b, actual %0b",
                     $time, want.last, dout_if.last_out);
            mismatches++;
          end
        end
      end
      if (cfg_if.valid && cfg_if.ready) mode_model = cfg_if.encrypt_mode;
      if (din_if.valid && din_if.ready) begin
        case (din_if.opcode)
          OP_RESTART: begin
            key0_model = K0_SEED;
            key1_model = K1_SEED;
            key2_model = K2_SEED;
          end
          OP_ABSORB: cipher_absorb(din_if.byte_value);
          OP_DATA: begin
            coded = din_if.byte_value ^ keystream_byte(key2_model);
            cipher_absorb(mode_model ? din_if.byte_value : coded);
            pending_results.push_back('{data: coded, last: din_if.last_in});
          end
          default: ;
        endcase
      end
    end
    if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Result receiver: random stalls, one long hold on request, none once calm
  initial begin : result_sink
    int n;
    dout_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_results) begin
        dout_if.ready <= 1'b0;
        for (n = 1; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_results = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        dout_if.ready <= 1'b0;
        n = $urandom_range(1, 3);
        repeat (n - 1) @(posedge clk);
      end else begin
        dout_if.ready <= 1'b1;
      end
    end
  end

  // valid stays high after acceptance so back-to-back items need no second assignment
  task automatic send_item(input logic [1:0] op, input logic [7:0] value, input logic last);
    int gap;
    gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
    if (gap != 0) begin
      din_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    din_if.valid      <= 1'b1;
    din_if.opcode     <= op;
    din_if.byte_value <= value;
    din_if.last_in    <= last;
    do @(posedge clk); while (!din_if.ready);
    if (op != OP_UNUSED) items_sent++;
  endtask

  // Mode only changes with the block drained; password items leave no result to wait on
  task automatic write_mode(input logic enc);
    din_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_if.valid        <= 1'b1;
    cfg_if.encrypt_mode <= enc;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_directed_cases();
    write_mode(1'b1);
    // data straight from the reset keys
    send_item(OP_DATA, 8'h00, 1'b0);
    send_item(OP_DATA, 8'hFF, 1'b1);
    // last marker must not restart the keys
    send_item(OP_DATA, 8'h80, 1'b0);
    send_item(OP_UNUSED, 8'hFF, 1'b1);
    send_item(OP_ABSORB, 8'h00, 1'b0);
    send_item(OP_ABSORB, 8'hFF, 1'b1);
    send_item(OP_DATA, 8'h01, 1'b1);
    send_item(OP_RESTART, 8'hA5, 1'b1);
    send_item(OP_DATA, 8'h00, 1'b0);
    send_item(OP_DATA, 8'h7F, 1'b1);
    write_mode(1'b0);
    send_item(OP_RESTART, 8'h00, 1'b0);
    send_item(OP_ABSORB, 8'hFF, 1'b0);
    send_item(OP_ABSORB, 8'h00, 1'b0);
    send_item(OP_ABSORB, 8'h5A, 1'b0);
    send_item(OP_DATA, 8'hFF, 1'b0);
    send_item(OP_DATA, 8'h00, 1'b0);
    send_item(OP_UNUSED, 8'h00, 1'b0);
    send_item(OP_DATA, 8'h55, 1'b1);
    send_item(OP_DATA, 8'hAA, 1'b0);
  endtask

  // Mostly restart, password, data with last on the final byte; some noise and broken ones
  task automatic send_message();
    int kind;
    int pw_len;
    int data_len;
    int i;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 6))
        send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
    end else begin
      if (kind != 1)
        send_item(OP_RESTART, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      pw_len = $urandom_range(0, 12);
      for (i = 0; i < pw_len; i++)
        send_item(OP_ABSORB, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      data_len = $urandom_range(1, 24);
      for (i = 0; i < data_len; i++)
        send_item(OP_DATA, 8'($urandom_range(0, 255)), (i == data_len - 1) || (kind == 2));
    end
  endtask

  task automatic test_random_traffic();
    int phase;
    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      write_mode(phase < 2 ? phase[0] : 1'($urandom_range(0, 1)));
      repeat ($urandom_range(3, 8)) send_message();
      phase++;
    end
  endtask

  task automatic test_result_backpressure();
    int i;
    write_mode(1'($urandom_range(0, 1)));
    hold_results = 1'b1;
    send_item(OP_RESTART, 8'h00, 1'b0);
    for (i = 0; i < 40; i++) send_item(OP_DATA, 8'($urandom_range(0, 255)), i == 39);
  endtask

  task automatic test_calm_tail();
    int i;
    write_mode(1'($urandom_range(0, 1)));
    calm = 1'b1;
    send_item(OP_RESTART, 8'h00, 1'b0);
    repeat (4) send_item(OP_ABSORB, 8'($urandom_range(0, 255)), 1'b0);
    for (i = 0; i < 50; i++) send_item(OP_DATA, 8'($urandom_range(0, 255)), i == 49);
  endtask

  initial begin
    din_if.valid        <= 1'b0;
    din_if.opcode       <= OP_RESTART;
    din_if.byte_value   <= 8'h00;
    din_if.last_in      <= 1'b0;
    cfg_if.valid        <= 1'b0;
    cfg_if.encrypt_mode <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_random_traffic();
    test_result_backpressure();
    test_calm_tail();
    din_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
sv/zipc_pkg.sv
sv/zipc_ifs.sv
sv/zipc_keys.sv
sv/zip_traditional_stream_cipher.sv
verif/zip_traditional_stream_cipher_tb.sv
